>>> design/esmc_pkg.sv
// Shared types, codes and constants of the straight move controller.
package esmc_pkg;

  localparam int CFG_W = 18;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_RUN     = 3'd1;
  localparam logic [2:0] PH_DONE    = 3'd2;
  localparam logic [2:0] PH_TIMEOUT = 3'd3;
  localparam logic [2:0] PH_ABORT   = 3'd4;

  localparam logic [2:0] REG_TARGET  = 3'd0;
  localparam logic [2:0] REG_TOTAL   = 3'd1;
  localparam logic [2:0] REG_CRUISE  = 3'd2;
  localparam logic [2:0] REG_MIN     = 3'd3;
  localparam logic [2:0] REG_DECEL   = 3'd4;
  localparam logic [2:0] REG_TOL     = 3'd5;
  localparam logic [2:0] REG_STALL   = 3'd6;
  localparam logic [2:0] REG_GAIN    = 3'd7;

  localparam int MIN_TARGET = 359;
  localparam int MAX_TARGET = 35920;
  localparam int UPDATE_MS = 20;
  localparam int PROGRESS_STEP2 = 8;
  localparam int MAX_CORR = 1792;
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [1:0]         op;
    logic [31:0]        now_ms;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               auto_mode;
    logic               debug_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         move_state;
    logic               accepted;
    logic               enter_auto;
    logic               stop_robot;
    logic               speed_valid;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
  } out_item_t;

  typedef struct packed {
    logic       load_item;
    logic       calc;
    logic       eval;
    logic       start_move;
    logic       upd_time;
    logic       upd_prog;
    logic       ramp_calc;
    logic       div_load;
    logic       div_step;
    logic       spd_calc;
    logic       load_out;
    logic [2:0] move_state;
    logic       accepted;
    logic       enter_auto;
    logic       stop_robot;
    logic       speed_valid;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       auto_mode;
    logic       debug_on;
    logic       target_ok;
    logic       tick_due;
    logic       total_over;
    logic       done_hit;
    logic       progress_made;
    logic       stall_over;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

>>> design/encoder_straight_move_controller_unit.sv
// Top level of the encoder straight move controller.
// A start request arms a straight move over the programmed distance in encoder
// counts, a cancel request aborts a running move, and tick requests run the
// control law at most once per 20 ms, each request giving exactly one result.
// Start, cancel, ignored and finishing ticks pass the calc, eval and decide
// states on their way to the result register; a tick that produces wheel speeds
// also passes the ramp, divider load, divider and speed states, with the
// 32-step restoring divider forming the deceleration ramp. The result register
// is loaded only once it is free: empty, or its result being taken.
// One request is worked on at a time; a new request is taken as soon as the
// previous one has reached the output register, even if that result is still
// stalled. Configuration writes are always ready and should only be issued
// while the block is idle.
module encoder_straight_move_controller_unit #(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  esmc_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output esmc_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [esmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [esmc_pkg::CFG_W-1:0]     cfg_data
);
  import esmc_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // Register writes never wait.
  assign cfg_ready = 1'b1;

  // The sequencer owns the move phase and walks each request through the datapath.
  esmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds the registers, the progress arithmetic, the divider and
  // the output register.
  esmc_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

>>> design/esmc_ctrl.sv
// Sequencer of the straight move controller: move phase and item flow.
module esmc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  esmc_pkg::stat_t st,
  output esmc_pkg::cmd_t  cmd
);
  import esmc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CALC  = 4'd1;
  localparam logic [3:0] S_EVAL  = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_RAMP  = 4'd4;
  localparam logic [3:0] S_DLOAD = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_SPD   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;

  logic [3:0] state, state_next;
  logic [2:0] phase, phase_next;
  logic       res_acc, res_acc_next;
  logic       res_stop, res_stop_next;
  logic       res_sv, res_sv_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      phase    <= PH_IDLE;
      res_acc  <= 1'b0;
      res_stop <= 1'b0;
      res_sv   <= 1'b0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      res_acc  <= res_acc_next;
      res_stop <= res_stop_next;
      res_sv   <= res_sv_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    phase_next    = phase;
    res_acc_next  = res_acc;
    res_stop_next = res_stop;
    res_sv_next   = res_sv;
    cmd           = '0;
    cmd.move_state  = phase;
    cmd.accepted    = res_acc;
    cmd.enter_auto  = res_acc;
    cmd.stop_robot  = res_stop;
    cmd.speed_valid = res_sv;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        res_acc_next  = 1'b0;
        res_stop_next = 1'b0;
        res_sv_next   = 1'b0;
        state_next    = S_WB;
        if (st.op == OP_START) begin
          if (phase != PH_RUN && !st.debug_on && st.target_ok) begin
            cmd.start_move = 1'b1;
            phase_next     = PH_RUN;
            res_acc_next   = 1'b1;
          end
        end else if (st.op == OP_CANCEL) begin
          if (phase == PH_RUN) begin
            phase_next    = PH_ABORT;
            res_stop_next = st.auto_mode;
          end
        end else if (st.op == OP_TICK && phase == PH_RUN) begin
          if (!st.auto_mode || st.debug_on) begin
            phase_next = PH_ABORT;
          end else if (st.tick_due) begin
            cmd.upd_time = 1'b1;
            if (st.total_over) begin
              phase_next    = PH_TIMEOUT;
              res_stop_next = 1'b1;
            end else if (st.done_hit) begin
              phase_next    = PH_DONE;
              res_stop_next = 1'b1;
            end else if (st.progress_made) begin
              cmd.upd_prog = 1'b1;
              state_next   = S_RAMP;
            end else if (st.stall_over) begin
              phase_next    = PH_TIMEOUT;
              res_stop_next = 1'b1;
            end else begin
              state_next = S_RAMP;
            end
          end
        end
      end
      S_RAMP: begin
        cmd.ramp_calc = 1'b1;
        state_next    = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_SPD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_SPD: begin
        cmd.spd_calc = 1'b1;
        res_sv_next  = 1'b1;
        state_next   = S_WB;
      end
      S_WB: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/esmc_dp.sv
// Datapath of the straight move controller: registers, progress math, divider, speeds.
module esmc_dp #(
  parameter int COUNT_WIDTH = 32,
  parameter int TIME_WIDTH  = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [esmc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [esmc_pkg::CFG_W-1:0]        cfg_data,
  input  esmc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output esmc_pkg::out_item_t               out_data,
  input  esmc_pkg::cmd_t                    cmd,
  output esmc_pkg::stat_t                   st
);
  import esmc_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int PW = CW + 3;
  localparam int AW = (CW + 2 > 21) ? CW + 2 : 21;
  localparam int XW = (TW > 18) ? TW : 18;

  // Configuration registers.
  logic signed [16:0] r_target;
  logic [17:0]        r_total;
  logic [13:0]        r_cruise, r_min;
  logic [15:0]        r_decel, r_tol, r_stall, r_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_target <= 17'sd7184;
      r_total  <= 18'd28684;
      r_cruise <= 14'd8960;
      r_min    <= 14'd2304;
      r_decel  <= 16'd1293;
      r_tol    <= 16'd29;
      r_stall  <= 16'd3000;
      r_gain   <= 16'd1638;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET: r_target <= cfg_data[16:0];
        REG_TOTAL:  r_total  <= cfg_data;
        REG_CRUISE: r_cruise <= cfg_data[13:0];
        REG_MIN:    r_min    <= cfg_data[13:0];
        REG_DECEL:  r_decel  <= cfg_data[15:0];
        REG_TOL:    r_tol    <= cfg_data[15:0];
        REG_STALL:  r_stall  <= cfg_data[15:0];
        REG_GAIN:   r_gain   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Item register.
  logic [1:0]    it_op;
  logic [TW-1:0] it_now;
  logic [CW-1:0] it_lc, it_rc;
  logic          it_auto, it_debug;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_op    <= in_data.op;
      it_now   <= in_data.now_ms[TW-1:0];
      it_lc    <= in_data.left_count[CW-1:0];
      it_rc    <= in_data.right_count[CW-1:0];
      it_auto  <= in_data.auto_mode;
      it_debug <= in_data.debug_on;
    end
  end

  // Move state.
  logic [CW-1:0]        left_base, right_base;
  logic signed [CW+1:0] best;
  logic [TW-1:0]        start_time, progress_time, update_time;
  logic signed [CW+1:0] psum, ldiff;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_base     <= '0;
      right_base    <= '0;
      best          <= '0;
      start_time    <= '0;
      progress_time <= '0;
      update_time   <= '0;
    end else begin
      if (cmd.start_move) begin
        left_base     <= it_lc;
        right_base    <= it_rc;
        best          <= '0;
        start_time    <= it_now;
        progress_time <= it_now;
        update_time   <= it_now;
      end
      if (cmd.upd_time) begin
        update_time <= it_now;
      end
      if (cmd.upd_prog) begin
        best          <= psum;
        progress_time <= it_now;
      end
    end
  end

  logic signed [17:0] target_w;
  logic [16:0]        abs_t;
  logic               dir_neg;
  assign target_w = {r_target[16], r_target};
  assign dir_neg  = r_target[16];
  assign abs_t    = dir_neg ? 17'(-target_w) : 17'(target_w);

  // First stage: signed progress per wheel and elapsed times.
  logic [CW-1:0]      dl, dr;
  logic signed [CW:0] dl_s, dr_s, lp, rp;
  logic [TW-1:0]      dt_upd, dt_start, dt_prog;
  assign dl   = it_lc - left_base;
  assign dr   = it_rc - right_base;
  assign dl_s = {dl[CW-1], dl};
  assign dr_s = {dr[CW-1], dr};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      lp       <= dir_neg ? -dl_s : dl_s;
      rp       <= dir_neg ? -dr_s : dr_s;
      dt_upd   <= it_now - update_time;
      dt_start <= it_now - start_time;
      dt_prog  <= it_now - progress_time;
    end
  end

  // Second stage: progress sum, doubled remaining distance, wheel difference.
  logic signed [PW-1:0] rem2;
  logic signed [PW-1:0] two_abs;
  assign two_abs = PW'({abs_t, 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      psum  <= {lp[CW], lp} + {rp[CW], rp};
      ldiff <= {lp[CW], lp} - {rp[CW], rp};
      rem2  <= two_abs - {lp[CW], lp[CW], lp} - {rp[CW], rp[CW], rp};
    end
  end

  logic signed [PW-1:0] two_tol, two_decel, psum_w, best_w;
  assign two_tol   = PW'({r_tol, 1'b0});
  assign two_decel = PW'({r_decel, 1'b0});
  assign psum_w    = {psum[CW+1], psum};
  assign best_w    = {best[CW+1], best};

  // Ramp numerator and correction product.
  logic              ramp_on, num_neg, corr_neg;
  logic [13:0]       span;
  logic [30:0]       num_mag;
  logic [CW+1:0]     ld_abs_n;
  logic [AW-1:0]     ld_abs;
  logic [20:0]       dmag;
  logic [36:0]       corr_prod;
  assign span     = (r_min > r_cruise) ? (r_min - r_cruise) : (r_cruise - r_min);
  assign ld_abs_n = ldiff[CW+1] ? (CW+2)'(-ldiff) : (CW+2)'(ldiff);
  assign ld_abs   = AW'(ld_abs_n);
  assign dmag     = (ld_abs >= AW'(21'h100000)) ? 21'h100000 : ld_abs[20:0];

  always_ff @(posedge clk) begin
    if (cmd.ramp_calc) begin
      ramp_on   <= (r_decel != 16'd0) && (rem2 < two_decel);
      num_neg   <= r_min > r_cruise;
      num_mag   <= 31'(span) * 31'(rem2[16:0]);
      corr_neg  <= ldiff[CW+1];
      corr_prod <= 37'(r_gain) * 37'(dmag);
    end
  end

  // Restoring divider: (num + decel) / (2 * decel), one quotient bit a cycle.
  logic [31:0] dvd;
  logic [16:0] rmd;
  logic [16:0] dsr;
  logic [17:0] shifted;
  logic [5:0]  div_cnt;
  assign dsr     = {r_decel, 1'b0};
  assign shifted = {rmd, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= 6'(DIV_STEPS);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd <= 32'(num_mag) + 32'(r_decel);
      rmd <= '0;
    end else if (cmd.div_step) begin
      if (shifted >= {1'b0, dsr}) begin
        rmd <= 17'(shifted - {1'b0, dsr});
        dvd <= {dvd[30:0], 1'b1};
      end else begin
        rmd <= shifted[16:0];
        dvd <= {dvd[30:0], 1'b0};
      end
    end
  end

  // Speeds.
  logic signed [17:0] q_s, base;
  logic [36:0]        cm_full;
  logic [10:0]        cm;
  logic signed [18:0] corr, l_raw, r_raw;
  logic signed [19:0] l_dir, r_dir;
  logic signed [15:0] lsp, rsp;

  assign q_s     = num_neg ? -$signed({2'b00, dvd[15:0]}) : $signed({2'b00, dvd[15:0]});
  assign base    = ramp_on ? ($signed({4'b0000, r_min}) + q_s) : $signed({4'b0000, r_cruise});
  assign cm_full = (corr_prod + 37'd128) >> 8;
  assign cm      = (cm_full > 37'(MAX_CORR)) ? 11'(MAX_CORR) : cm_full[10:0];
  assign corr    = corr_neg ? -$signed({8'd0, cm}) : $signed({8'd0, cm});
  assign l_raw   = {base[17], base} - corr;
  assign r_raw   = {base[17], base} + corr;
  assign l_dir   = dir_neg ? -{l_raw[18], l_raw} : {l_raw[18], l_raw};
  assign r_dir   = dir_neg ? -{r_raw[18], r_raw} : {r_raw[18], r_raw};

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.spd_calc) begin
      lsp <= sat16(l_dir);
      rsp <= sat16(r_dir);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.move_state  <= cmd.move_state;
      out_data.accepted    <= cmd.accepted;
      out_data.enter_auto  <= cmd.enter_auto;
      out_data.stop_robot  <= cmd.stop_robot;
      out_data.speed_valid <= cmd.speed_valid;
      out_data.left_speed  <= cmd.speed_valid ? lsp : 16'sd0;
      out_data.right_speed <= cmd.speed_valid ? rsp : 16'sd0;
    end
  end

  assign st.op            = it_op;
  assign st.auto_mode     = it_auto;
  assign st.debug_on      = it_debug;
  assign st.target_ok     = (abs_t >= 17'(MIN_TARGET)) && (abs_t <= 17'(MAX_TARGET));
  assign st.tick_due      = dt_upd >= TW'(UPDATE_MS);
  assign st.total_over    = XW'(dt_start) > XW'(r_total);
  assign st.done_hit      = rem2 <= two_tol;
  assign st.progress_made = psum_w >= best_w + PW'(PROGRESS_STEP2);
  assign st.stall_over    = dt_prog > TW'(r_stall);
  assign st.div_done      = div_cnt == 6'd0;
  assign st.out_free      = !out_valid || !out_stall;

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the encoder straight move controller.
module testbench;
  import esmc_pkg::*;

  // Operation code that the block does not define.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  encoder_straight_move_controller_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Limit: a watchdog for the slowest correct run of roughly 1600 requests
  // plus stalls, gaps, drains and register writes.
  initial begin
    #20000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Register copy kept by the predictor.
  logic signed [16:0] m_target;
  logic [17:0] m_total;
  logic [13:0] m_cruise, m_min;
  logic [15:0] m_decel, m_tol, m_stall, m_gain;
  // Controller state copy.
  logic [2:0] m_phase;
  logic [31:0] m_lbase, m_rbase, m_tstart, m_tprog, m_tupd;
  longint m_best;

  out_item_t speed_results_due[$];
  int n_mismatch = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_speed = 0;
  int n_done = 0;
  int n_timeout = 0;
  bit long_hold = 1'b0;
  bit stall_random = 1'b1;

  // Rounded division, ties away from zero.
  function automatic longint round_div(longint num, longint den);
    longint a;
    longint q;
    a = num < 0 ? -num : num;
    q = (2 * a + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] sat16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Predict the result of one request and advance the state copy.
  function automatic out_item_t predict_move(in_item_t it);
    out_item_t r;
    longint absT, dir, lp, rp, psum, rem2, base, corr;
    logic [31:0] dl, dr;
    r = '0;
    absT = m_target < 0 ? -longint'(m_target) : longint'(m_target);
    dir = m_target < 0 ? -1 : 1;
    if (it.op == OP_START) begin
      if (m_phase != PH_RUN && !it.debug_on && absT >= MIN_TARGET && absT <= MAX_TARGET) begin
        m_lbase = it.left_count;
        m_rbase = it.right_count;
        m_best = 0;
        m_tstart = it.now_ms;
        m_tprog = it.now_ms;
        m_tupd = it.now_ms;
        m_phase = PH_RUN;
        r.accepted = 1'b1;
        r.enter_auto = 1'b1;
      end
    end else if (it.op == OP_CANCEL) begin
      if (m_phase == PH_RUN) begin
        m_phase = PH_ABORT;
        r.stop_robot = it.auto_mode;
      end
    end else if (it.op == OP_TICK && m_phase == PH_RUN) begin
      if (!it.auto_mode || it.debug_on) begin
        m_phase = PH_ABORT;
      end else if (32'(it.now_ms - m_tupd) >= UPDATE_MS) begin
        m_tupd = it.now_ms;
        if (32'(it.now_ms - m_tstart) > m_total) begin
          m_phase = PH_TIMEOUT;
          r.stop_robot = 1'b1;
        end else begin
          dl = it.left_count - m_lbase;
          dr = it.right_count - m_rbase;
          lp = dir * longint'($signed(dl));
          rp = dir * longint'($signed(dr));
          psum = lp + rp;
          rem2 = 2 * absT - psum;
          if (rem2 <= 2 * longint'(m_tol)) begin
            m_phase = PH_DONE;
            r.stop_robot = 1'b1;
          end else if (psum < m_best + PROGRESS_STEP2 &&
                       32'(it.now_ms - m_tprog) > m_stall) begin
            m_phase = PH_TIMEOUT;
            r.stop_robot = 1'b1;
          end else begin
            if (psum >= m_best + PROGRESS_STEP2) begin
              m_best = psum;
              m_tprog = it.now_ms;
            end
            base = m_cruise;
            if (m_decel != 0 && rem2 < 2 * longint'(m_decel))
              base = longint'(m_min) + round_div((longint'(m_cruise) - longint'(m_min)) * rem2,
                                                 2 * longint'(m_decel));
            corr = round_div(longint'(m_gain) * (lp - rp), 256);
            if (corr > MAX_CORR) corr = MAX_CORR;
            if (corr < -MAX_CORR) corr = -MAX_CORR;
            r.left_speed = sat16(dir * (base - corr));
            r.right_speed = sat16(dir * (base + corr));
            r.speed_valid = 1'b1;
          end
        end
      end
    end
    r.move_state = m_phase;
    return r;
  endfunction

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      n_checked++;
      if (speed_results_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_data);
      end else begin
        e = speed_results_due.pop_front();
        if (e.speed_valid) n_speed++;
        if (e.stop_robot && e.move_state == PH_DONE) n_done++;
        if (e.move_state == PH_TIMEOUT && e.stop_robot) n_timeout++;
        if (out_data.move_state !== e.move_state || out_data.accepted !== e.accepted ||
            out_data.enter_auto !== e.enter_auto || out_data.stop_robot !== e.stop_robot ||
            out_data.speed_valid !== e.speed_valid || out_data.left_speed !== e.left_speed ||
            out_data.right_speed !== e.right_speed) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: expected %h got %h", e, out_data);
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off.
  always @(posedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (!stall_random) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  int burst_left = 0;

  // Sends one request, with random bursts and gaps on the sender side. The block
  // stalls after each request that it takes, so the idle cycle between two
  // requests of a burst never slows the burst down.
  task automatic send_request(in_item_t it);
    @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    speed_results_due.push_back(predict_move(it));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    in_valid <= 1'b0;
    n_sent++;
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (speed_results_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  // One register write; the caller drops cfg_valid after its last write.
  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET: m_target = val[16:0];
      REG_TOTAL:  m_total = val[17:0];
      REG_CRUISE: m_cruise = val[13:0];
      REG_MIN:    m_min = val[13:0];
      REG_DECEL:  m_decel = val[15:0];
      REG_TOL:    m_tol = val[15:0];
      REG_STALL:  m_stall = val[15:0];
      default:    m_gain = val[15:0];
    endcase
  endtask

  task automatic set_move(int target, int total, int cruise, int minr, int decel,
                          int tol, int stall, int gain);
    write_reg(REG_TARGET, CFG_W'(target));
    write_reg(REG_TOTAL, CFG_W'(total));
    write_reg(REG_CRUISE, CFG_W'(cruise));
    write_reg(REG_MIN, CFG_W'(minr));
    write_reg(REG_DECEL, CFG_W'(decel));
    write_reg(REG_TOL, CFG_W'(tol));
    write_reg(REG_STALL, CFG_W'(stall));
    write_reg(REG_GAIN, CFG_W'(gain));
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_req(logic [1:0] op, logic [31:0] t, logic [31:0] l,
                                        logic [31:0] r, logic am, logic dbg);
    in_item_t it;
    it.op = op;
    it.now_ms = t;
    it.left_count = l;
    it.right_count = r;
    it.auto_mode = am;
    it.debug_on = dbg;
    return it;
  endfunction

  // Directed requests: refused starts, cancel, early ticks, abort, wraps.
  task automatic test_directed();
    set_move(-35920, 0, 16383, 0, 65535, 0, 0, 65535);
    send_request(make_req(OP_TICK, 32'hFFFF_FFFF, 0, 0, 1, 0));
    send_request(make_req(OP_CANCEL, 0, 0, 0, 1, 0));
    send_request(make_req(OP_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1));
    send_request(make_req(OP_START, 32'hFFFF_FFF0, 32'h7FFF_FFF0, 32'h8000_0000, 1, 1));
    send_request(make_req(OP_START, 32'hFFFF_FFF0, 32'h7FFF_FFF0, 32'h8000_0000, 1, 0));
    send_request(make_req(OP_START, 0, 0, 0, 1, 0));
    send_request(make_req(OP_TICK, 32'hFFFF_FFF5, 0, 0, 1, 0));
    send_request(make_req(OP_TICK, 32'h0000_0004, 32'h7FFF_FF00, 32'h8000_0010, 1, 0));
    send_request(make_req(OP_TICK, 32'h0000_0040, 32'h7FFF_FF00, 32'h8000_0010, 1, 0));
    send_request(make_req(OP_START, 100, 0, 0, 1, 0));
    drain_results();
    set_move(359, 200000, 100, 16383, 1, 0, 65535, 0);
    send_request(make_req(OP_START, 0, 5, 5, 1, 0));
    send_request(make_req(OP_TICK, 30, 300, 200, 1, 0));
    send_request(make_req(OP_TICK, 60, 600, 600, 1, 0));
    send_request(make_req(OP_START, 70, 0, 0, 0, 0));
    send_request(make_req(OP_TICK, 100, 0, 0, 0, 0));
    send_request(make_req(OP_START, 110, 0, 0, 1, 0));
    send_request(make_req(OP_CANCEL, 120, 0, 0, 0, 0));
    send_request(make_req(OP_START, 130, 0, 0, 1, 0));
    send_request(make_req(OP_TICK, 140, 0, 0, 1, 1));
    drain_results();
    set_move(358, 5, 0, 0, 0, 65535, 0, 1);
    send_request(make_req(OP_START, 0, 0, 0, 1, 0));
    drain_results();
    set_move(35921, 5, 0, 0, 0, 65535, 0, 1);
    send_request(make_req(OP_START, 0, 0, 0, 1, 0));
    drain_results();
  endtask

  // Random well-formed moves with random noise and broken sequences mixed in.
  task automatic test_random_moves(int n_items);
    int sent;
    logic [31:0] t, l, r;
    int step, targ;
    sent = 0;
    while (sent < n_items) begin
      targ = $urandom_range(300, 8000);
      if ($urandom_range(0, 1)) targ = -targ;
      if ($urandom_range(0, 15) == 0) targ = $urandom_range(0, 1) ? 35920 : -35920;
      set_move(targ, $urandom_range(0, 3) == 0 ? $urandom_range(0, 400) : $urandom_range(0, 200000),
               $urandom_range(0, 16383), $urandom_range(0, 16383),
               $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 65535),
               $urandom_range(0, 60), $urandom_range(0, 3) == 0 ? $urandom_range(0, 200) : 3000,
               $urandom);
      t = $urandom;
      l = $urandom;
      r = $urandom;
      send_request(make_req(OP_START, t, l, r, 1, $urandom_range(0, 20) == 0));
      sent++;
      repeat ($urandom_range(5, 40)) begin
        step = $urandom_range(0, 600);
        t = t + $urandom_range(0, 50);
        l = l + ((targ < 0) ? -step : step) + $urandom_range(0, 40) - 20;
        r = r + ((targ < 0) ? -step : step) + $urandom_range(0, 40) - 20;
        case ($urandom_range(0, 39))
          0: send_request(make_req(OP_CANCEL, t, l, r, $urandom_range(0, 1), 0));
          1: send_request(make_req(OP_TICK, t, l, r, 0, 0));
          2: send_request(make_req(OP_TICK, t, l, r, 1, 1));
          3: send_request(make_req(OP_UNKNOWN, $urandom, $urandom, $urandom, 1, 0));
          4: send_request(make_req(OP_START, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 1), $urandom_range(0, 1)));
          5: send_request(make_req(OP_TICK, $urandom, $urandom, $urandom, 1, 0));
          default: send_request(make_req(OP_TICK, t, l, r, 1, 0));
        endcase
        sent++;
      end
      drain_results();
    end
  endtask

  // Long receiver hold-off while requests keep coming, then a full drain and random moves without receiver stalls.
  task automatic test_backpressure();
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      begin
        set_move(1000, 200000, 5000, 1000, 500, 10, 3000, 1000);
        send_request(make_req(OP_START, 0, 0, 0, 1, 0));
        for (int i = 1; i <= 12; i++)
          send_request(make_req(OP_TICK, 20 * i, 30 * i, 31 * i, 1, 0));
      end
    join
    drain_results();
    stall_random = 1'b0;
    test_random_moves(40);
    stall_random = 1'b1;
  endtask

  initial begin
    int guard;
    m_phase = PH_IDLE;
    m_lbase = '0; m_rbase = '0; m_tstart = '0; m_tprog = '0; m_tupd = '0; m_best = 0;
    m_target = 17'sd7184; m_total = 28684; m_cruise = 8960; m_min = 2304;
    m_decel = 1293; m_tol = 29; m_stall = 3000; m_gain = 1638;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // Wait after reset before the first request; the block itself needs no clearing pass.
    repeat (5) @(posedge clk);
    // First some requests under the reset register values.
    send_request(make_req(OP_START, 5, 0, 0, 1, 0));
    send_request(make_req(OP_TICK, 30, 100, 90, 1, 0));
    drain_results();
    test_directed();
    test_backpressure();
    test_random_moves(1450);
    guard = 0;
    while (speed_results_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d requests, checked %0d results: %0d with speeds, %0d done, %0d timeouts.",
             n_sent, n_checked, n_speed, n_done, n_timeout);
    if (n_mismatch == 0 && speed_results_due.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d results missing", n_mismatch, speed_results_due.size());
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
